/* src/tmas_pkg.sv */
`timescale 1ns / 1ps
// Package for the trajectory moving-average smoother: widths, payload types
// and the saturation helper shared by the interfaces and modules. No dependencies.

package tmas_pkg;

	localparam int DELTA_W      = 32;
	localparam int TRAJ_W       = 48;
	localparam int IDX_W        = 32;
	localparam int RADIUS_W     = 6;
	localparam int MAX_RADIUS   = 63;
	localparam int RADIUS_RESET = 30;
	localparam int RING_DEPTH   = 128;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int DIV_W        = RADIUS_W + 1;
	localparam int SUM_W        = TRAJ_W + RING_AW;
	localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [TRAJ_W-1:0]  traj_t;
	typedef logic signed [TRAJ_W:0]    ext_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [RADIUS_W-1:0]       radius_t;
	typedef logic [RING_AW-1:0]        ring_addr_t;
	typedef logic [DIV_W-1:0]          divisor_t;

	typedef struct packed {
		traj_t x;
		traj_t y;
		traj_t angle;
	} traj3_t;

	// clip a one-bit-wider value to the trajectory range
	function automatic traj_t sat_traj(input ext_t v);
		traj_t res;
		if (v[TRAJ_W] != v[TRAJ_W-1]) begin
			res = v[TRAJ_W] ? {1'b1, {(TRAJ_W-1){1'b0}}} : {1'b0, {(TRAJ_W-1){1'b1}}};
		end else begin
			res = v[TRAJ_W-1:0];
		end
		return res;
	endfunction

endpackage

/* src/tmas_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for frame deltas and smoothed results.
// Depends on tmas_pkg.

interface tmas_delta_if;
	logic              valid;
	logic              ready;
	tmas_pkg::delta_t  delta_x;
	tmas_pkg::delta_t  delta_y;
	tmas_pkg::delta_t  delta_angle;
	logic              end_of_sequence;

	modport source (output valid, delta_x, delta_y, delta_angle, end_of_sequence,
		input ready);
	modport sink (input valid, delta_x, delta_y, delta_angle, end_of_sequence,
		output ready);
endinterface

interface tmas_result_if;
	logic             valid;
	logic             ready;
	tmas_pkg::idx_t   point_index;
	tmas_pkg::traj_t  smooth_x;
	tmas_pkg::traj_t  smooth_y;
	tmas_pkg::traj_t  smooth_angle;
	tmas_pkg::traj_t  corr_x;
	tmas_pkg::traj_t  corr_y;
	tmas_pkg::traj_t  corr_angle;
	logic             was_smoothed;
	logic             last_of_run;

	modport source (output valid, point_index, smooth_x, smooth_y, smooth_angle,
		corr_x, corr_y, corr_angle, was_smoothed, last_of_run, input ready);
	modport sink (input valid, point_index, smooth_x, smooth_y, smooth_angle,
		corr_x, corr_y, corr_angle, was_smoothed, last_of_run, output ready);
endinterface

/* src/trajectory_moving_average_smoother.sv */
`timescale 1ns / 1ps
// Top level of the trajectory moving-average smoother: delta accumulation,
// raw trajectory ring, window summation and serial mean. Depends on tmas_pkg,
// tmas_if, tmas_ram and tmas_sdiv.

// Each accepted frame delta is added, with saturation, to the running x, y and
// angle trajectory and written to a 128-entry ring. The point R frames behind
// the newest is then emitted; an item with end_of_sequence emits every pending
// point up to the newest, the last result flagged last_of_run, and restarts the
// sequence. A raw (edge) point goes from its ring read through ST_RAW_RD,
// ST_RAW_CAP and ST_LOAD to the output register. A smoothed point takes one
// ring read per cycle over the 2R+1 window points, then a bit-serial divide,
// run in three parallel lanes, one per axis. Further flush points go out raw.
// The block takes a new delta once the last result of the previous one sits in
// the output register. The ring needs no clearing after reset.

module trajectory_moving_average_smoother (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  tmas_pkg::radius_t     cfg_wdata,
	tmas_delta_if.sink            deltas,
	tmas_result_if.source         results
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW_RD,
		ST_RAW_CAP,
		ST_SUM,
		ST_SUM_TAIL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MEAN,
		ST_LOAD
	} state_t;

	state_t                state_q;
	tmas_pkg::radius_t     radius_q;
	tmas_pkg::traj3_t      cum_q;
	tmas_pkg::idx_t        count_q;
	tmas_pkg::radius_t     r_q;
	tmas_pkg::idx_t        p_q;
	tmas_pkg::idx_t        pend_q;
	logic                  smooth_q;
	tmas_pkg::ring_addr_t  j_q;
	tmas_pkg::divisor_t    left_q;
	logic                  rd_vld_s1;

	tmas_pkg::sum_t        acc_q [3];
	tmas_pkg::traj3_t      raw_q;
	tmas_pkg::traj3_t      mean_q;

	logic                  out_vld_q;
	tmas_pkg::idx_t        out_idx_q;
	tmas_pkg::traj3_t      out_smooth_q;
	tmas_pkg::traj3_t      out_corr_q;
	logic                  out_sm_q;
	logic                  out_last_q;

	tmas_pkg::radius_t     r_use;
	tmas_pkg::divisor_t    twice_r;
	logic                  n_ge_r;
	logic                  n_ge_2r;
	tmas_pkg::idx_t        p_first;
	tmas_pkg::ring_addr_t  win_start;
	tmas_pkg::traj3_t      cum_new;
	tmas_pkg::traj3_t      corr;
	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	tmas_pkg::ring_addr_t  raddr;
	tmas_pkg::traj3_t      rdata;
	tmas_pkg::traj_t       rd_ax [3];
	tmas_pkg::traj_t       quot [3];
	logic [2:0]            div_busy;

	always_comb begin
		r_use     = (radius_q > tmas_pkg::MAX_RADIUS) ?
			tmas_pkg::radius_t'(tmas_pkg::MAX_RADIUS) : radius_q;
		twice_r   = {r_use, 1'b0};
		n_ge_r    = count_q >= tmas_pkg::idx_t'(r_use);
		n_ge_2r   = count_q >= tmas_pkg::idx_t'(twice_r);
		p_first   = n_ge_r ? count_q - tmas_pkg::idx_t'(r_use) : '0;
		win_start = count_q[tmas_pkg::RING_AW-1:0] - tmas_pkg::ring_addr_t'(twice_r);

		cum_new.x     = tmas_pkg::sat_traj(tmas_pkg::ext_t'(cum_q.x) +
			tmas_pkg::ext_t'(deltas.delta_x));
		cum_new.y     = tmas_pkg::sat_traj(tmas_pkg::ext_t'(cum_q.y) +
			tmas_pkg::ext_t'(deltas.delta_y));
		cum_new.angle = tmas_pkg::sat_traj(tmas_pkg::ext_t'(cum_q.angle) +
			tmas_pkg::ext_t'(deltas.delta_angle));

		corr.x     = tmas_pkg::sat_traj(tmas_pkg::ext_t'(mean_q.x) -
			tmas_pkg::ext_t'(raw_q.x));
		corr.y     = tmas_pkg::sat_traj(tmas_pkg::ext_t'(mean_q.y) -
			tmas_pkg::ext_t'(raw_q.y));
		corr.angle = tmas_pkg::sat_traj(tmas_pkg::ext_t'(mean_q.angle) -
			tmas_pkg::ext_t'(raw_q.angle));

		accept   = deltas.valid && deltas.ready;
		out_free = !out_vld_q || results.ready;
		out_load = (state_q == ST_LOAD) && out_free;
		raddr    = (state_q == ST_SUM) ? j_q : p_q[tmas_pkg::RING_AW-1:0];

		rd_ax[0] = rdata.x;
		rd_ax[1] = rdata.y;
		rd_ax[2] = rdata.angle;
	end

	assign deltas.ready = (state_q == ST_IDLE);

	assign results.valid        = out_vld_q;
	assign results.point_index  = out_idx_q;
	assign results.smooth_x     = out_smooth_q.x;
	assign results.smooth_y     = out_smooth_q.y;
	assign results.smooth_angle = out_smooth_q.angle;
	assign results.corr_x       = out_corr_q.x;
	assign results.corr_y       = out_corr_q.y;
	assign results.corr_angle   = out_corr_q.angle;
	assign results.was_smoothed = out_sm_q;
	assign results.last_of_run  = out_last_q;

	tmas_ram #(
		.WIDTH ($bits(tmas_pkg::traj3_t)),
		.DEPTH (tmas_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (accept),
		.waddr (count_q[tmas_pkg::RING_AW-1:0]),
		.wdata (cum_new),
		.raddr (raddr),
		.rdata (rdata)
	);

	for (genvar a = 0; a < 3; a++) begin : g_div
		tmas_sdiv u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (state_q == ST_DIV_GO),
			.dividend (acc_q[a]),
			.divisor  ({r_q, 1'b1}),
			.busy     (div_busy[a]),
			.quotient (quot[a])
		);
	end

	// window accumulation and captured operands
	always_ff @(posedge clk) begin
		if (state_q == ST_RAW_CAP) begin
			raw_q <= rdata;
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= '0;
			end
		end else if (rd_vld_s1) begin
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= acc_q[a] + tmas_pkg::sum_t'(rd_ax[a]);
			end
		end
		if (state_q == ST_MEAN) begin
			mean_q <= {quot[0], quot[1], quot[2]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			radius_q     <= tmas_pkg::radius_t'(tmas_pkg::RADIUS_RESET);
			cum_q        <= '0;
			count_q      <= '0;
			r_q          <= '0;
			p_q          <= '0;
			pend_q       <= '0;
			smooth_q     <= 1'b0;
			j_q          <= '0;
			left_q       <= '0;
			rd_vld_s1    <= 1'b0;
			out_vld_q    <= 1'b0;
			out_idx_q    <= '0;
			out_smooth_q <= '0;
			out_corr_q   <= '0;
			out_sm_q     <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			rd_vld_s1 <= (state_q == ST_SUM);
			out_vld_q <= out_load || (out_vld_q && !results.ready);

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cum_q    <= deltas.end_of_sequence ? '0 : cum_new;
						count_q  <= deltas.end_of_sequence ? '0 : count_q + 1'b1;
						r_q      <= r_use;
						p_q      <= p_first;
						pend_q   <= deltas.end_of_sequence ? count_q : p_first;
						smooth_q <= n_ge_2r;
						j_q      <= win_start;
						if (deltas.end_of_sequence || n_ge_r) begin
							state_q <= ST_RAW_RD;
						end
					end
				end
				ST_RAW_RD: begin
					state_q <= ST_RAW_CAP;
				end
				ST_RAW_CAP: begin
					left_q  <= {r_q, 1'b1};
					state_q <= smooth_q ? ST_SUM : ST_LOAD;
				end
				ST_SUM: begin
					j_q    <= j_q + 1'b1;
					left_q <= left_q - 1'b1;
					if (left_q == 1) begin
						state_q <= ST_SUM_TAIL;
					end
				end
				ST_SUM_TAIL: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_busy == 3'b000) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						out_idx_q    <= p_q;
						out_smooth_q <= smooth_q ? mean_q : raw_q;
						out_corr_q   <= smooth_q ? corr : '0;
						out_sm_q     <= smooth_q;
						out_last_q   <= (p_q == pend_q);
						smooth_q     <= 1'b0;
						if (p_q == pend_q) begin
							state_q <= ST_IDLE;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_RAW_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/tmas_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module tmas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/tmas_sdiv.sv */
`timescale 1ns / 1ps
// Bit-serial signed divider by a small odd divisor, truncating toward zero:
// one quotient bit per cycle through a shift register. Depends on tmas_pkg.

module tmas_sdiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tmas_pkg::sum_t      dividend,
	input  tmas_pkg::divisor_t  divisor,
	output logic                busy,
	output tmas_pkg::traj_t     quotient
);

	logic                             busy_q;
	logic [tmas_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                             neg_q;
	logic [tmas_pkg::SUM_W-1:0]       sh_q;
	tmas_pkg::divisor_t               rem_q;
	tmas_pkg::divisor_t               dvs_q;
	logic [tmas_pkg::DIV_W:0]         trial;
	logic [tmas_pkg::DIV_W:0]         diff;
	logic                             take;
	tmas_pkg::sum_t                   q_full;

	always_comb begin
		trial  = {rem_q, sh_q[tmas_pkg::SUM_W-1]};
		diff   = trial - {1'b0, dvs_q};
		take   = trial >= {1'b0, dvs_q};
		q_full = neg_q ? -$signed(sh_q) : $signed(sh_q);
	end

	assign busy     = busy_q;
	assign quotient = q_full[tmas_pkg::TRAJ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= tmas_pkg::DIV_CNT_W'(tmas_pkg::SUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[tmas_pkg::SUM_W-1];
			sh_q  <= dividend[tmas_pkg::SUM_W-1] ? -dividend : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[tmas_pkg::DIV_W-1:0] : trial[tmas_pkg::DIV_W-1:0];
			sh_q  <= {sh_q[tmas_pkg::SUM_W-2:0], take};
		end
	end

endmodule
